// ===== rtl/core/bdpl_pkg.sv =====
// ----------------------------------------------------------------------------
// bdpl_pkg: shared types and constants for the button press-length detector
// Mode codes, register indexes, reset limits and the timer control word.
// ----------------------------------------------------------------------------
package bdpl_pkg;

  localparam int COUNT_WIDTH_DEF = 24;   // default timer width
  localparam int CFG_DATA_W      = 24;   // widest config register
  localparam int CFG_INDEX_W     = 1;    // two registers

  localparam logic [31:0] SETTLE_TICKS_RST = 32'd30000;
  localparam logic [31:0] LONG_TICKS_RST   = 32'd1000000;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_TICKS   = 1'd1;

  // debounce machine, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'b001,
    MODE_SETTLING = 3'b010,
    MODE_HELD     = 3'b100
  } mode_t;

  // timer control for one accepted tick
  typedef struct packed {
    logic tick;    // advance on this tick
    logic start;   // restart from zero, running
    logic stop;    // clear and halt
  } timer_ctl_t;

endpackage

// ===== rtl/core/bdpl_tick_if.sv =====
// ----------------------------------------------------------------------------
// bdpl_tick_if: input channel, one sampled button level per word
// valid/ready handshake; a word moves when both are high.
// ----------------------------------------------------------------------------
interface bdpl_tick_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// ===== rtl/core/bdpl_result_if.sv =====
// ----------------------------------------------------------------------------
// bdpl_result_if: result channel, press pulses and held status per word
// valid/ready handshake; a word moves when both are high.
// ----------------------------------------------------------------------------
interface bdpl_result_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic held;

  modport source (output valid, output short_press, output long_press,
                  output held, input ready);
  modport sink   (input valid, input short_press, input long_press,
                  input held, output ready);
endinterface

// ===== rtl/core/bdpl_timer.sv =====
// ----------------------------------------------------------------------------
// bdpl_timer: tick counter that halts when it reaches its limit
// Fire is shown combinationally for the tick being taken.
// ----------------------------------------------------------------------------
module bdpl_timer #(
  parameter int COUNT_WIDTH = bdpl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  bdpl_pkg::timer_ctl_t    ctl,
  input  logic [COUNT_WIDTH-1:0]  limit,
  output logic                    fire
);
  import bdpl_pkg::*;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   running;
  logic                   running_next;
  logic [COUNT_WIDTH-1:0] count_inc;

  assign count_inc = count + COUNT_WIDTH'(1);
  // limit of zero acts like one: inc is never zero unless it wraps
  assign fire      = running && (count_inc >= limit);

  always_comb begin
    count_next   = count;
    running_next = running;
    if (ctl.tick) begin
      if (running) begin
        count_next   = count_inc;
        running_next = !fire;
      end
      if (ctl.start) begin
        count_next   = '0;
        running_next = 1'b1;
      end else if (ctl.stop) begin
        count_next   = '0;
        running_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      running <= 1'b0;
    end else begin
      count   <= count_next;
      running <= running_next;
    end
  end

endmodule

// ===== rtl/core/button_debounce_press_length.sv =====
// ----------------------------------------------------------------------------
// button_debounce_press_length: debounced button with short/long press
// Edge detect, settle timer, long-press timer and an idle/settling/held
// machine; one result word per input word.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Payload                            Accept
// tick      in    pin_level (0 pressed, 1 released)  valid & ready
// result    out   short_press, long_press, held      valid & ready
// cfg       in    cfg_index, cfg_data                cfg_we
//
// One word per cycle while result.ready is high; a word's result appears in the result
// register on the cycle after it is taken.
// All decisions come from the current state and the incoming level in one
// pass of logic ahead of the result register.
// tick.ready is low only while a result sits unclaimed and result.ready is
// low; timers and the machine advance only on taken words, so stalls on
// either side do not disturb timing in ticks.
// Synchronous reset: machine to idle, previous level to released, timers
// stopped, limits back to 30000 and 1000000 (truncated to COUNT_WIDTH).
//
module button_debounce_press_length #(
  parameter int COUNT_WIDTH = bdpl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bdpl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bdpl_pkg::CFG_DATA_W-1:0]    cfg_data,
  bdpl_tick_if.sink                          tick,
  bdpl_result_if.source                      result
);
  import bdpl_pkg::*;

  localparam int EXT_W = CFG_DATA_W + COUNT_WIDTH;

  // limits
  logic [COUNT_WIDTH-1:0] settle_ticks;
  logic [COUNT_WIDTH-1:0] long_ticks;
  logic [EXT_W-1:0]       cfg_ext;
  logic [COUNT_WIDTH-1:0] cfg_val;

  // machine state
  mode_t mode;
  mode_t mode_next;
  logic  previous_level;
  logic  long_expired;
  logic  long_expired_next;

  // per-word decode
  logic       take;
  logic       fall;
  logic       rise;
  logic       settle_fire;
  logic       long_fire;
  logic       long_exp_tick;
  logic       short_next;
  logic       long_next;
  timer_ctl_t settle_ctl;
  timer_ctl_t long_ctl;

  // output register
  logic out_valid;
  logic out_short;
  logic out_long;
  logic out_held;

  // ---- handshake: result register frees the input side ----
  assign tick.ready = !out_valid || result.ready;
  assign take       = tick.valid && tick.ready;

  assign result.valid       = out_valid;
  assign result.short_press = out_short;
  assign result.long_press  = out_long;
  assign result.held        = out_held;

  // ---- configuration: 24-bit data cut or widened to the timer width ----
  assign cfg_ext = EXT_W'(cfg_data);
  assign cfg_val = cfg_ext[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= COUNT_WIDTH'(SETTLE_TICKS_RST);
      long_ticks   <= COUNT_WIDTH'(LONG_TICKS_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SETTLE_TICKS: settle_ticks <= cfg_val;
        REG_LONG_TICKS:   long_ticks   <= cfg_val;
        default: ;
      endcase
    end
  end

  // ---- edges against last taken level ----
  assign fall = previous_level && !tick.pin_level;
  assign rise = !previous_level && tick.pin_level;

  // ---- timers ----
  bdpl_timer #(.COUNT_WIDTH(COUNT_WIDTH)) u_settle (
    .clk   (clk),
    .rst   (rst),
    .ctl   (settle_ctl),
    .limit (settle_ticks),
    .fire  (settle_fire)
  );

  bdpl_timer #(.COUNT_WIDTH(COUNT_WIDTH)) u_long (
    .clk   (clk),
    .rst   (rst),
    .ctl   (long_ctl),
    .limit (long_ticks),
    .fire  (long_fire)
  );

  // long timer expiry on this tick counts before the machine looks at it
  assign long_exp_tick = long_expired || long_fire;

  // ---- mode machine ----
  always_comb begin
    mode_next         = mode;
    long_expired_next = long_exp_tick;
    short_next        = 1'b0;
    long_next         = 1'b0;
    settle_ctl        = '{tick: take, start: 1'b0, stop: 1'b0};
    long_ctl          = '{tick: take, start: 1'b0, stop: 1'b0};
    case (mode)
      MODE_SETTLING: begin
        // edges are dropped here; the level at expiry decides
        if (settle_fire) begin
          mode_next = tick.pin_level ? MODE_IDLE : MODE_HELD;
        end
      end
      MODE_HELD: begin
        // press edges ignored; release reports and re-settles
        if (rise) begin
          long_next         = long_exp_tick;
          short_next        = !long_exp_tick;
          long_expired_next = 1'b0;
          long_ctl.stop     = 1'b1;
          settle_ctl.start  = 1'b1;
          mode_next         = MODE_SETTLING;
        end
      end
      default: begin
        // idle: expiry flag never survives a tick here
        long_expired_next = 1'b0;
        mode_next         = MODE_IDLE;
        if (fall) begin
          settle_ctl.start = 1'b1;
          long_ctl.start   = 1'b1;
          mode_next        = MODE_SETTLING;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      previous_level <= 1'b1;
      long_expired   <= 1'b0;
    end else if (take) begin
      mode           <= mode_next;
      previous_level <= tick.pin_level;
      long_expired   <= long_expired_next;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_short <= short_next;
      out_long  <= long_next;
      out_held  <= (mode_next == MODE_HELD);
    end
  end

endmodule

// ===== rtl/core/bdpl_checker.sv =====
// ----------------------------------------------------------------------------
// bdpl_checker: port-level checks for the press-length detector
// Bound to the top level; watches the tick and result channels only.
// ----------------------------------------------------------------------------
module bdpl_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic short_press,
  input logic long_press,
  input logic held
);

  // a taken word always yields a result next cycle
  a_word_yields_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("taken word produced no result");

  // no result appears without a taken word
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(in_valid && in_ready)) |=> !out_valid)
    else $error("result without a taken word");

  // a press is either short or long, never both
  a_one_press_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(short_press && long_press))
    else $error("short and long press together");

  // a release report leaves the held state
  a_release_not_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (short_press || long_press)) |-> !held)
    else $error("held still set on release");

  // stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(short_press) && $stable(long_press) && $stable(held)))
    else $error("stalled result changed");

endmodule

bind button_debounce_press_length bdpl_checker u_bdpl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (tick.valid),
  .in_ready    (tick.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .short_press (result.short_press),
  .long_press  (result.long_press),
  .held        (result.held)
);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: button_debounce_press_length
// Drives sampled button levels through the tick channel and checks every
// result word against an in-bench model of the debounce and press-length
// machine, across several settle/long limit settings.
// ----------------------------------------------------------------------------
module testbench;
  import bdpl_pkg::*;

  // Generous bound: ~1900 words, each at worst an idle gap on the
  // sender plus receiver stalls, one long hold-off and the config pauses.
  localparam int CYCLE_LIMIT = 200000;

  // Idling on both sides stops inside this window of words.
  localparam int QUIET_FROM = 900;
  localparam int QUIET_TO   = 1200;

  // Word count at which the receiver holds off for a long stretch.
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 60;

  localparam int PHASE_WORDS = 205;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic held;
  } press_word_t;

  // --------------------------------------------------------------------------
  // Press-length scoreboard: mirrors the debounce machine one tick at a time
  // and keeps the expected result words in order.
  // --------------------------------------------------------------------------
  class press_scoreboard;
    logic [CFG_DATA_W-1:0] settle_limit;
    logic [CFG_DATA_W-1:0] long_limit;
    mode_t                 mode;
    bit                    prev_level;
    logic [CFG_DATA_W-1:0] settle_count;
    bit                    settle_run;
    logic [CFG_DATA_W-1:0] long_count;
    bit                    long_run;
    bit                    long_exp;
    press_word_t           expected_words[$];
    int                    errors;

    function new();
      settle_limit = SETTLE_TICKS_RST[CFG_DATA_W-1:0];
      long_limit   = LONG_TICKS_RST[CFG_DATA_W-1:0];
      mode         = MODE_IDLE;
      prev_level   = 1'b1;
      settle_count = '0;
      settle_run   = 1'b0;
      long_count   = '0;
      long_run     = 1'b0;
      long_exp     = 1'b0;
      errors       = 0;
    endfunction

    function void set_limit(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      if (index == REG_SETTLE_TICKS) begin
        settle_limit = value;
      end else begin
        long_limit = value;
      end
    endfunction

    // one tick of a running timer; a zero limit acts like one
    function bit bump(inout logic [CFG_DATA_W-1:0] cnt, inout bit run,
                      input logic [CFG_DATA_W-1:0] lim);
      if (!run) return 1'b0;
      cnt = cnt + 1'b1;
      if (cnt >= lim) begin
        run = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_level(bit level);
      bit          fall;
      bit          rise;
      bit          settle_done;
      press_word_t w;
      fall       = prev_level && !level;
      rise       = !prev_level && level;
      prev_level = level;
      settle_done = bump(settle_count, settle_run, settle_limit);
      if (bump(long_count, long_run, long_limit)) long_exp = 1'b1;
      w = '0;
      case (mode)
        MODE_SETTLING: begin
          // edges are dropped here; only the settle expiry matters
          if (settle_done) mode = level ? MODE_IDLE : MODE_HELD;
        end
        MODE_HELD: begin
          if (rise) begin
            if (long_exp) begin
              long_exp     = 1'b0;
              w.long_press = 1'b1;
            end else begin
              w.short_press = 1'b1;
            end
            long_run     = 1'b0;
            long_count   = '0;
            settle_count = '0;
            settle_run   = 1'b1;
            mode         = MODE_SETTLING;
          end
        end
        default: begin
          // idle wipes a stale long expiry, even one landing this tick
          mode     = MODE_IDLE;
          long_exp = 1'b0;
          if (fall) begin
            settle_count = '0;
            settle_run   = 1'b1;
            long_count   = '0;
            long_run     = 1'b1;
            mode         = MODE_SETTLING;
          end
        end
      endcase
      w.held = (mode == MODE_HELD);
      expected_words.push_back(w);
    endfunction

    function void compare_bit(string field, logic exp_v, logic act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %b, got %b", $time, field, exp_v, act_v);
      end
    endfunction

    function void check_word(press_word_t got);
      press_word_t exp_w;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, got %b/%b/%b", $time,
                 got.short_press, got.long_press, got.held);
        return;
      end
      exp_w = expected_words.pop_front();
      compare_bit("short_press", exp_w.short_press, got.short_press);
      compare_bit("long_press", exp_w.long_press, got.long_press);
      compare_bit("held", exp_w.held, got.held);
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bdpl_tick_if   tick_ch ();
  bdpl_result_if result_ch ();

  button_debounce_press_length i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (result_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  press_scoreboard sb = new();

  int cycle_count   = 0;
  int words_sent    = 0;
  int results_seen  = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // Watchdog: a hung handshake or a drain that never empties ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side. Outputs are read right at the edge, before any nonblocking
  // update lands, so a word counts exactly when valid and ready were high.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_word('{result_ch.short_press, result_ch.long_press, result_ch.held});
      results_seen <= results_seen + 1;
    end
  end

  // Receiver: random stalls, one long hold-off that backs the block up into
  // the tick channel, and a quiet window with no stalls at all.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      result_ch.ready <= 1'b0;
      hold_left       <= HOLD_CYCLES;
      hold_done       <= 1'b1;
    end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= 11);
    end
  end

  // --------------------------------------------------------------------------
  // Tick side
  // --------------------------------------------------------------------------

  // Offer one level; returns on the edge that takes it. valid is only
  // dropped for a one-cycle gap, never lowered and raised in one step.
  task automatic send_tick(bit level);
    if (!(words_sent >= QUIET_FROM && words_sent < QUIET_TO) &&
        $urandom_range(99) < 11) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.pin_level <= level;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    sb.note_level(level);
    words_sent++;
  endtask

  task automatic send_run(bit level, int len);
    repeat (len) send_tick(level);
  endtask

  // Let the block go quiet: every expected word back, plus a pause
  // for the one-deep result register.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Both limits, back to back; only called while the block is idle.
  task automatic set_limits(logic [CFG_DATA_W-1:0] settle_lim,
                            logic [CFG_DATA_W-1:0] long_lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SETTLE_TICKS;
    cfg_data  <= settle_lim;
    @(posedge clk);
    sb.set_limit(REG_SETTLE_TICKS, settle_lim);
    cfg_index <= REG_LONG_TICKS;
    cfg_data  <= long_lim;
    @(posedge clk);
    sb.set_limit(REG_LONG_TICKS, long_lim);
    cfg_we <= 1'b0;
  endtask

  // A realistic press: contact bounce going down, a hold whose length
  // straddles the long limit, bounce coming up, then a rest long enough
  // to settle back to idle. Lengths are capped so huge limits stay cheap.
  task automatic play_press(logic [CFG_DATA_W-1:0] settle_lim,
                            logic [CFG_DATA_W-1:0] long_lim);
    int sc;
    int lc;
    sc = (settle_lim > 20) ? 20 : ((settle_lim == 0) ? 1 : int'(settle_lim));
    lc = (long_lim > 60) ? 60 : ((long_lim == 0) ? 1 : int'(long_lim));
    repeat ($urandom_range(2, 0)) begin
      send_run(1'b0, $urandom_range(2, 1));
      send_run(1'b1, $urandom_range(2, 1));
    end
    send_run(1'b0, $urandom_range(sc + lc + 4, 1));
    repeat ($urandom_range(2, 0)) begin
      send_run(1'b1, $urandom_range(2, 1));
      send_run(1'b0, $urandom_range(2, 1));
    end
    send_run(1'b1, $urandom_range(sc + 4, 1));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] settle_set[6];
    logic [CFG_DATA_W-1:0] long_set[6];
    logic [CFG_DATA_W-1:0] s_lim;
    logic [CFG_DATA_W-1:0] l_lim;
    int                    phase_start;
    bit                    reset_levels[7];
    bit                    zero_levels[16];

    settle_set = '{24'd1, 24'd1, 24'd3, 24'hFFFFFF, 24'd2, 24'd4};
    long_set   = '{24'd1, 24'd7, 24'd20, 24'd4, 24'hFFFFFF, 24'd12};

    // reset limits: a press starts settling but 30000 ticks never pass
    reset_levels = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

    // settle limit 0 with long limit 3:
    //   press, release -> long press (long timer running since reset levels)
    //   release bounce while settling -> ignored, settles back to held,
    //   then release -> short press; hold past long limit -> long press
    //   tap that settles released while the long timer still runs, so it
    //   expires in idle and must be forgotten by the next press
    zero_levels = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                    1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    cfg_we            = 1'b0;
    cfg_index         = REG_SETTLE_TICKS;
    cfg_data          = '0;
    tick_ch.valid     = 1'b0;
    tick_ch.pin_level = 1'b1;
    rst               = 1'b1;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (reset_levels[i]) send_tick(reset_levels[i]);
    drain();

    set_limits(24'd0, 24'd3);
    foreach (zero_levels[i]) send_tick(zero_levels[i]);
    drain();

    // Random phases: fixed corners first, including both maximum limits,
    // then small random limits. Mostly well-formed presses, some noise.
    for (int p = 0; p < 9; p++) begin
      if (p < 6) begin
        s_lim = settle_set[p];
        l_lim = long_set[p];
      end else begin
        s_lim = CFG_DATA_W'($urandom_range(6, 1));
        l_lim = CFG_DATA_W'($urandom_range(50, 1));
      end
      set_limits(s_lim, l_lim);
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        if ($urandom_range(99) < 85) begin
          play_press(s_lim, l_lim);
        end else begin
          repeat ($urandom_range(10, 1)) send_tick($urandom_range(1, 0) != 0);
        end
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d words never arrived", sb.errors, sb.outstanding());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
